[rtl/u8u16_pkg.sv]
// Shared types and constants for the UTF-8 to UTF-16 stream decoder.
package u8u16_pkg;

  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // front-end mode
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_COLLECT = 2'd1;
  localparam logic [1:0] MODE_DROP    = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_STRAY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic [30:0] MAX_BMP     = 31'h0000_FFFF;
  localparam logic [30:0] MAX_UNICODE = 31'h0010_FFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h1_0000;
  localparam logic [15:0] HI_SURR     = 16'hD800;
  localparam logic [15:0] LO_SURR     = 16'hDC00;

  // work item passed from front to back
  typedef struct packed {
    logic        is_value;  // 1: finished code point, 0: marker/error
    logic [30:0] value;
    logic [1:0]  status;    // marker status
    logic        done;      // marker ends the string
  } cmd_t;

  typedef struct packed {
    logic [15:0] unit;
    logic [1:0]  status;
    logic        done;
    logic        last;
  } res_t;

endpackage

[rtl/u8u16_front.sv]
// Front end: takes bytes, tracks sequence state, issues work items.
module u8u16_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        in_byte_i,
  output logic              cmd_valid_o,
  output u8u16_pkg::cmd_t   cmd_o
);
  import u8u16_pkg::*;

  logic [1:0]  mode_q, mode_d;
  logic [30:0] acc_q, acc_d;
  logic [2:0]  rem_q, rem_d;
  logic        cmd_valid;
  logic [30:0] acc_shift;
  logic [2:0]  rem_dec;

  assign acc_shift = {acc_q[24:0], in_byte_i[5:0]};
  assign rem_dec   = rem_q - 3'd1;

  always_comb begin
    mode_d    = mode_q;
    acc_d     = acc_q;
    rem_d     = rem_q;
    cmd_valid = 1'b0;
    cmd_o     = '{is_value: 1'b0, value: '0, status: ST_OK, done: 1'b0};
    case (mode_q)
      MODE_DROP: begin
        if (in_byte_i == 8'h00) mode_d = MODE_IDLE;
      end
      MODE_COLLECT: begin
        if (in_byte_i == 8'h00) begin
          mode_d       = MODE_IDLE;
          acc_d        = '0;
          rem_d        = '0;
          cmd_valid    = 1'b1;
          cmd_o.status = ST_TRUNC;
          cmd_o.done   = 1'b1;
        end else begin
          acc_d = acc_shift;
          rem_d = rem_dec;
          if (rem_dec == 3'd0) begin
            mode_d         = MODE_IDLE;
            acc_d          = '0;
            cmd_valid      = 1'b1;
            cmd_o.is_value = 1'b1;
            cmd_o.value    = acc_shift;
          end
        end
      end
      default: begin
        mode_d = MODE_IDLE;
        if (in_byte_i == 8'h00) begin
          cmd_valid  = 1'b1;
          cmd_o.done = 1'b1;
        end else if (in_byte_i inside {[8'h01:8'h7F]}) begin
          cmd_valid      = 1'b1;
          cmd_o.is_value = 1'b1;
          cmd_o.value    = {23'd0, in_byte_i};
        end else if (in_byte_i inside {[8'h80:8'hBF]}) begin
          mode_d       = MODE_DROP;
          cmd_valid    = 1'b1;
          cmd_o.status = ST_STRAY;
          cmd_o.done   = 1'b1;
        end else begin
          mode_d = MODE_COLLECT;
          if (in_byte_i >= 8'hFC) begin
            acc_d = {30'd0, in_byte_i[0]};
            rem_d = 3'd5;
          end else if (in_byte_i >= 8'hF8) begin
            acc_d = {29'd0, in_byte_i[1:0]};
            rem_d = 3'd4;
          end else if (in_byte_i >= 8'hF0) begin
            acc_d = {28'd0, in_byte_i[2:0]};
            rem_d = 3'd3;
          end else if (in_byte_i >= 8'hE0) begin
            acc_d = {27'd0, in_byte_i[3:0]};
            rem_d = 3'd2;
          end else begin
            acc_d = {26'd0, in_byte_i[4:0]};
            rem_d = 3'd1;
          end
        end
      end
    endcase
  end

  assign cmd_valid_o = accept_i && cmd_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      acc_q  <= '0;
      rem_q  <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      rem_q  <= rem_d;
    end
  end

endmodule

[rtl/u8u16_cmd_fifo.sv]
// Short register queue of work items between front and back.
module u8u16_cmd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  u8u16_pkg::cmd_t   wdata_i,
  input  logic              pop_i,
  output u8u16_pkg::cmd_t   rdata_o,
  output logic              full_o,
  output logic              empty_o
);
  import u8u16_pkg::*;

  cmd_t                 mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMD_CNT_W-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == CMD_CNT_W'(CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

[rtl/u8u16_back.sv]
// Back end: turns work items into UTF-16 results in an output register.
module u8u16_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_avail_i,
  input  u8u16_pkg::cmd_t   cmd_i,
  output logic              cmd_pop_o,
  input  logic              out_pop_i,
  output logic              out_valid_o,
  output u8u16_pkg::res_t   out_o
);
  import u8u16_pkg::*;

  res_t        out_q, out_d;
  logic        out_valid_q;
  logic        pend_q;
  logic [15:0] pend_unit_q, pend_unit_d;
  logic        pend_set;
  logic        out_free;
  logic [20:0] supp;

  assign out_free  = !out_valid_q || out_pop_i;
  assign cmd_pop_o = cmd_avail_i && out_free && !pend_q;
  assign supp      = cmd_i.value[20:0] - SUPP_BASE;

  always_comb begin
    pend_set    = 1'b0;
    pend_unit_d = LO_SURR | {6'd0, supp[9:0]};
    out_d       = '{unit: 16'd0, status: cmd_i.status, done: cmd_i.done, last: 1'b1};
    if (cmd_i.is_value) begin
      out_d.status = ST_OK;
      out_d.done   = 1'b0;
      if (cmd_i.value <= MAX_BMP) begin
        out_d.unit = cmd_i.value[15:0];
      end else if (cmd_i.value <= MAX_UNICODE) begin
        // high surrogate now, low surrogate held for the next slot
        out_d.unit = HI_SURR | {6'd0, supp[19:10]};
        out_d.last = 1'b0;
        pend_set   = 1'b1;
      end else begin
        out_d.status = ST_RANGE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (pend_q) out_q <= '{unit: pend_unit_q, status: ST_OK, done: 1'b0, last: 1'b1};
      else if (cmd_pop_o) out_q <= out_d;
    end
    if (cmd_pop_o && pend_set) pend_unit_q <= pend_unit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= pend_q || cmd_avail_i;
      if (pend_q) pend_q <= 1'b0;
      else if (cmd_pop_o) pend_q <= pend_set;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

[rtl/utf8_to_utf16_stream_decoder.sv]
// UTF-8 byte stream to UTF-16 code unit decoder, top level.
// The first result of a byte passes the work queue and then the output register.
// Throughput: one byte per cycle while full is low; a surrogate pair gives two results,
// and full rises only when the result side falls behind the two-entry work queue.
// A two-entry work queue separates the byte front end from the result back end.
// Reset (async, active low) clears mode, sequence state, queue and output valid.
module utf8_to_utf16_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] code_unit_o,
  output logic [1:0]  status_o,
  output logic        string_done_o,
  output logic        last_o
);
  import u8u16_pkg::*;

  cmd_t cmd_in, cmd_out;
  logic cmd_push, cmd_pop, cmd_full, cmd_empty;
  logic accept;
  logic out_valid;
  res_t res;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  u8u16_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .cmd_valid_o (cmd_push),
    .cmd_o       (cmd_in)
  );

  u8u16_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .full_o  (cmd_full),
    .empty_o (cmd_empty)
  );

  u8u16_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_avail_i (!cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .out_pop_i   (pop),
    .out_valid_o (out_valid),
    .out_o       (res)
  );

  assign empty         = !out_valid;
  assign code_unit_o   = res.unit;
  assign status_o      = res.status;
  assign string_done_o = res.done;
  assign last_o        = res.last;

endmodule
